[design/svalloc_pkg.sv]
// ----------------------------------------------------------------------------
// svalloc_pkg
// Shared types and constants for the sound voice allocator: beat payloads,
// op and status codes, controller states and the scan carry between cells.
// ----------------------------------------------------------------------------
package svalloc_pkg;

	localparam int VOICES_DEF = 8;
	localparam logic [23:0] MIN_SAMPLES = 24'd4;
	localparam logic [7:0] CENTER_PAN = 8'd128;

	typedef enum logic [2:0] {
		OP_START   = 3'd0,
		OP_STARTED = 3'd1,
		OP_FREE    = 3'd2,
		OP_VOLUME  = 3'd3,
		OP_CLEAR   = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_GRANTED   = 3'd0,
		ST_SHORT     = 3'd1,
		ST_DUPLICATE = 3'd2,
		ST_NOVOICE   = 3'd3,
		ST_EVENT     = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LAUNCH1,
		S_SCAN1,
		S_LAUNCH2,
		S_SCAN2,
		S_DONE
	} state_t;

	typedef struct packed {
		op_t         op;
		logic [2:0]  voice;
		logic [7:0]  effect_id;
		logic [7:0]  sound_priority;
		logic        singular;
		logic [23:0] sample_count;
		logic        has_origin;
		logic [15:0] origin_id;
		logic [6:0]  volume;
		logic [7:0]  pan;
	} req_t;

	typedef struct packed {
		logic       granted;
		logic [2:0] voice_out;
		status_t    status;
		logic [7:0] pan_out;
	} rsp_t;

	typedef struct packed {
		logic done;
		logic dup;
		logic found;
	} carry_t;

	typedef struct packed {
		logic       set_started;
		logic       free;
		logic       set_volume;
		logic       clear;
		logic       assign_voice;
		logic [6:0] volume;
	} cmd_t;

endpackage

[design/svalloc_cell.sv]
// ----------------------------------------------------------------------------
// svalloc_cell
// One voice slot: holds the voice state and, when the scan token passes,
// updates the carry with this voice's verdict and hands it to the next cell.
// ----------------------------------------------------------------------------
module svalloc_cell
	import svalloc_pkg::*;
#(
	parameter int VOICES = VOICES_DEF,
	parameter int INDEX  = 0
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  req_t                      scan_req,
	input  logic                      pass2,
	input  logic                      tok_in,
	input  carry_t                    carry_in,
	input  logic [$clog2(VOICES)-1:0] pick_in,
	output logic                      tok_out,
	output carry_t                    carry_out,
	output logic [$clog2(VOICES)-1:0] pick_out,
	input  cmd_t                      cmd,
	input  logic [$clog2(VOICES)-1:0] cmd_idx
);

	localparam int IDX_W = $clog2(VOICES);
	localparam logic [IDX_W-1:0] ME = IDX_W'(INDEX);

	logic        active_q;
	logic [7:0]  sound_q;
	logic [7:0]  prio_q;
	logic        started_q;
	logic [6:0]  volume_q;
	logic        has_origin_q;
	logic [15:0] origin_q;

	logic        tok_q;
	carry_t      carry_q;
	logic [IDX_W-1:0] pick_q;

	carry_t      carry_d;
	logic [IDX_W-1:0] pick_d;
	logic        same;
	logic        hit;

	assign same = (scan_req.effect_id != 8'd0) && (sound_q == scan_req.effect_id);
	assign hit  = (cmd_idx == ME);

	always_comb begin
		carry_d = carry_in;
		pick_d  = pick_in;
		if (tok_in) begin
			if (pass2) begin
				if (!carry_in.found && (prio_q >= scan_req.sound_priority)) begin
					carry_d.found = 1'b1;
					pick_d        = ME;
				end
			end else if (!carry_in.done) begin
				if (same && !started_q) begin
					carry_d.done = 1'b1;
					if (volume_q < scan_req.volume) begin
						carry_d.found = 1'b1;
						pick_d        = ME;
					end else begin
						carry_d.dup = 1'b1;
					end
				end else if ((same && scan_req.singular) ||
						(scan_req.has_origin && has_origin_q &&
						(origin_q == scan_req.origin_id))) begin
					carry_d.done  = 1'b1;
					carry_d.found = 1'b1;
					pick_d        = ME;
				end else if (!active_q) begin
					carry_d.found = 1'b1;
					pick_d        = ME;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q   <= 1'b0;
			carry_q <= '0;
			pick_q  <= '0;
		end else begin
			tok_q   <= tok_in;
			carry_q <= carry_d;
			pick_q  <= pick_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= 1'b0;
			sound_q      <= '0;
			prio_q       <= '0;
			started_q    <= 1'b0;
			volume_q     <= '0;
			has_origin_q <= 1'b0;
			origin_q     <= '0;
		end else if (cmd.clear) begin
			active_q     <= 1'b0;
			sound_q      <= '0;
			prio_q       <= '0;
			started_q    <= 1'b0;
			volume_q     <= '0;
			has_origin_q <= 1'b0;
			origin_q     <= '0;
		end else if (hit) begin
			if (cmd.assign_voice) begin
				active_q     <= 1'b1;
				sound_q      <= scan_req.effect_id;
				prio_q       <= scan_req.sound_priority;
				started_q    <= 1'b0;
				volume_q     <= cmd.volume;
				has_origin_q <= scan_req.has_origin;
				origin_q     <= scan_req.has_origin ? scan_req.origin_id : 16'd0;
			end
			if (cmd.set_started) begin
				started_q <= 1'b1;
			end
			if (cmd.free) begin
				active_q <= 1'b0;
			end
			if (cmd.set_volume) begin
				volume_q <= cmd.volume;
			end
		end
	end

	assign tok_out   = tok_q;
	assign carry_out = carry_q;
	assign pick_out  = pick_q;

endmodule

[design/svalloc_ctrl.sv]
// ----------------------------------------------------------------------------
// svalloc_ctrl
// Sequencer: takes request beats, applies events, launches the scan token
// down the cell chain (match pass, then steal pass), writes the chosen voice
// and holds the response beat.
// ----------------------------------------------------------------------------
module svalloc_ctrl
	import svalloc_pkg::*;
#(
	parameter int VOICES = VOICES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_stall,
	input  req_t                      req,
	output logic                      rsp_valid,
	input  logic                      rsp_stall,
	output rsp_t                      rsp,
	output req_t                      scan_req,
	output logic                      inject,
	output logic                      pass2,
	input  logic                      last_tok,
	input  carry_t                    last_carry,
	input  logic [$clog2(VOICES)-1:0] last_pick,
	output cmd_t                      cmd,
	output logic [$clog2(VOICES)-1:0] cmd_idx
);

	localparam int IDX_W = $clog2(VOICES);

	state_t state_q, state_d;
	req_t   req_q;
	rsp_t   res_q, res_d;
	rsp_t   rsp_q;
	logic   rsp_valid_q;
	logic   accept;
	logic   load_out;
	logic   in_range;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign in_range  = (32'(req.voice) < 32'(VOICES));
	assign scan_req  = req_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		res_d    = res_q;
		cmd      = '0;
		cmd_idx  = IDX_W'(req.voice);
		inject   = 1'b0;
		pass2    = (state_q == S_LAUNCH2) || (state_q == S_SCAN2);
		load_out = 1'b0;
		unique case (state_q) inside
			S_IDLE: begin
				if (accept) begin
					res_d      = '0;
					res_d.status = ST_EVENT;
					cmd.volume = req.volume;
					state_d    = S_DONE;
					case (req.op)
						OP_START: begin
							if (req.sample_count < MIN_SAMPLES) begin
								res_d.status = ST_SHORT;
							end else begin
								state_d = S_LAUNCH1;
							end
						end
						OP_STARTED: cmd.set_started = in_range;
						OP_FREE:    cmd.free        = in_range;
						OP_VOLUME:  cmd.set_volume  = in_range;
						OP_CLEAR:   cmd.clear       = 1'b1;
						default:    ;
					endcase
				end
			end
			S_LAUNCH1, S_LAUNCH2: begin
				inject  = 1'b1;
				state_d = (state_q == S_LAUNCH1) ? S_SCAN1 : S_SCAN2;
			end
			S_SCAN1, S_SCAN2: begin
				cmd_idx = last_pick;
				if (last_tok) begin
					state_d = S_DONE;
					if ((state_q == S_SCAN1) && last_carry.done && last_carry.dup) begin
						res_d.status = ST_DUPLICATE;
					end else if (last_carry.found) begin
						cmd.assign_voice = 1'b1;
						cmd.volume       = req_q.volume;
						res_d.granted    = 1'b1;
						res_d.voice_out  = 3'(last_pick);
						res_d.status     = ST_GRANTED;
						res_d.pan_out    = req_q.has_origin ? CENTER_PAN : req_q.pan;
					end else if (state_q == S_SCAN1) begin
						state_d = S_LAUNCH2;
					end else begin
						res_d.status = ST_NOVOICE;
					end
				end
			end
			S_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		res_q <= res_d;
		if (load_out) begin
			rsp_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[design/sound_voice_allocator.sv]
// ----------------------------------------------------------------------------
// sound_voice_allocator
// Mixer voice table with priority stealing, built as a row of voice cells
// through which a scan token walks one cell per cycle.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  req_t (op, voice, sound ...)
//   rsp      out        rsp_valid / rsp_stall  rsp_t (granted, voice_out ...)
//
// Events and short starts go from accept straight to the done state, which
// loads the response beat. Starts walk the token down the cell chain for the
// match pass and, when that finds no voice, once more for the steal pass.
// One beat in flight; req_stall is high from accept until the response loads.
// Reset clears every voice; a stalled response holds and delays the next load.
// ----------------------------------------------------------------------------
module sound_voice_allocator
	import svalloc_pkg::*;
#(
	parameter int VOICES = VOICES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int IDX_W = $clog2(VOICES);

	req_t             scan_req;
	logic             inject;
	logic             pass2;
	cmd_t             cmd;
	logic [IDX_W-1:0] cmd_idx;
	logic [VOICES:0]  tok;
	carry_t           carry [VOICES+1];
	logic [IDX_W-1:0] pick  [VOICES+1];

	assign tok[0]   = inject;
	assign carry[0] = '0;
	assign pick[0]  = '0;

	for (genvar g = 0; g < VOICES; g++) begin : g_cell
		svalloc_cell #(
			.VOICES(VOICES),
			.INDEX (g)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.scan_req (scan_req),
			.pass2    (pass2),
			.tok_in   (tok[g]),
			.carry_in (carry[g]),
			.pick_in  (pick[g]),
			.tok_out  (tok[g+1]),
			.carry_out(carry[g+1]),
			.pick_out (pick[g+1]),
			.cmd      (cmd),
			.cmd_idx  (cmd_idx)
		);
	end

	svalloc_ctrl #(
		.VOICES(VOICES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.scan_req  (scan_req),
		.inject    (inject),
		.pass2     (pass2),
		.last_tok  (tok[VOICES]),
		.last_carry(carry[VOICES]),
		.last_pick (pick[VOICES]),
		.cmd       (cmd),
		.cmd_idx   (cmd_idx)
	);

endmodule

[design/svalloc_checker.sv]
// ----------------------------------------------------------------------------
// svalloc_checker
// Port-level checks on the allocator: response beat consistency and the
// one-beat-in-flight behaviour of the request channel.
// ----------------------------------------------------------------------------
module svalloc_checker
	import svalloc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_stall |=> req_valid && $stable(req))
		else $error("stalled request beat changed");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response beat changed");

	a_grant_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.granted == (rsp.status == ST_GRANTED)))
		else $error("granted flag disagrees with status");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.granted |-> (rsp.voice_out == 3'd0) && (rsp.pan_out == 8'd0))
		else $error("rejected beat carries voice or pan");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("second request taken while one is in flight");

endmodule

bind sound_voice_allocator svalloc_checker u_svalloc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_stall(req_stall),
	.req      (req),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.rsp      (rsp)
);

[tb/tb_sound_voice_allocator.sv]
// ----------------------------------------------------------------------------
// tb_sound_voice_allocator
// Self-checking bench for the voice allocator. Request beats come from a
// queue filled by the stimulus block: a directed opening, then random
// sequences over a small pool of sounds and origins. A voice table kept here
// predicts every response beat, which the monitor compares field by field.
// Both channels idle and stall at random, in three phases of differing load.
// ----------------------------------------------------------------------------
module tb_sound_voice_allocator;
	import svalloc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NV = VOICES_DEF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	req_t request_q[$];
	rsp_t allocation_q[$];
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatches = 0;
	rsp_t want;

	logic        tbl_active[NV] = '{default: 1'b0};
	logic [7:0]  tbl_sound[NV] = '{default: 8'd0};
	logic [7:0]  tbl_prio[NV] = '{default: 8'd0};
	logic        tbl_started[NV] = '{default: 1'b0};
	logic [6:0]  tbl_volume[NV] = '{default: 7'd0};
	logic        tbl_has_origin[NV] = '{default: 1'b0};
	logic [15:0] tbl_origin[NV] = '{default: 16'd0};
	logic [7:0]  tbl_pan[NV] = '{default: 8'd0};

	sound_voice_allocator i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	function automatic rsp_t allocate_voice(req_t r);
		rsp_t res;
		int pick;
		logic hit;
		res.granted = 1'b0;
		res.voice_out = 3'd0;
		res.status = ST_EVENT;
		res.pan_out = 8'd0;
		pick = -1;
		hit = 1'b0;
		if (r.op != OP_START) begin
			case (r.op)
				OP_STARTED: tbl_started[r.voice] = 1'b1;
				OP_FREE: tbl_active[r.voice] = 1'b0;
				OP_VOLUME: tbl_volume[r.voice] = r.volume;
				OP_CLEAR: begin
					for (int i = 0; i < NV; i++) begin
						tbl_active[i] = 1'b0;
						tbl_sound[i] = 8'd0;
						tbl_prio[i] = 8'd0;
						tbl_started[i] = 1'b0;
						tbl_volume[i] = 7'd0;
						tbl_has_origin[i] = 1'b0;
						tbl_origin[i] = 16'd0;
						tbl_pan[i] = 8'd0;
					end
				end
				default: ;
			endcase
			return res;
		end
		if (r.sample_count < MIN_SAMPLES) begin
			res.status = ST_SHORT;
			return res;
		end
		for (int i = 0; i < NV && !hit; i++) begin
			if (r.effect_id != 8'd0 && tbl_sound[i] == r.effect_id) begin
				if (!tbl_started[i]) begin
					if (tbl_volume[i] < r.volume) begin
						pick = i;
						hit = 1'b1;
					end else begin
						res.status = ST_DUPLICATE;
						return res;
					end
				end else if (r.singular) begin
					pick = i;
					hit = 1'b1;
				end
			end
			if (!hit && r.has_origin && tbl_has_origin[i] && tbl_origin[i] == r.origin_id) begin
				pick = i;
				hit = 1'b1;
			end
			if (!hit && !tbl_active[i])
				pick = i;
		end
		if (pick < 0) begin
			for (int i = 0; i < NV && pick < 0; i++)
				if (tbl_prio[i] >= r.sound_priority)
					pick = i;
			if (pick < 0) begin
				res.status = ST_NOVOICE;
				return res;
			end
		end
		tbl_active[pick] = 1'b1;
		tbl_sound[pick] = r.effect_id;
		tbl_prio[pick] = r.sound_priority;
		tbl_started[pick] = 1'b0;
		tbl_volume[pick] = r.volume;
		tbl_has_origin[pick] = r.has_origin;
		tbl_origin[pick] = r.has_origin ? r.origin_id : 16'd0;
		tbl_pan[pick] = r.has_origin ? CENTER_PAN : r.pan;
		res.granted = 1'b1;
		res.voice_out = 3'(pick);
		res.status = ST_GRANTED;
		res.pan_out = tbl_pan[pick];
		return res;
	endfunction

	function automatic req_t start_req(logic [7:0] snd, logic [7:0] prio, logic sing,
			logic [23:0] len, logic horg, logic [15:0] org, logic [6:0] vol, logic [7:0] pan);
		req_t r;
		r = '0;
		r.op = OP_START;
		r.effect_id = snd;
		r.sound_priority = prio;
		r.singular = sing;
		r.sample_count = len;
		r.has_origin = horg;
		r.origin_id = org;
		r.volume = vol;
		r.pan = pan;
		return r;
	endfunction

	function automatic req_t event_req(logic [2:0] op, logic [2:0] voice, logic [6:0] vol);
		req_t r;
		r = '0;
		r.op = op_t'(op);
		r.voice = voice;
		r.volume = vol;
		return r;
	endfunction

	function automatic req_t random_request();
		req_t r;
		int sel;
		sel = $urandom_range(99);
		if (sel < 55)
			r.op = OP_START;
		else if (sel < 70)
			r.op = OP_STARTED;
		else if (sel < 83)
			r.op = OP_FREE;
		else if (sel < 93)
			r.op = OP_VOLUME;
		else if (sel < 95)
			r.op = OP_CLEAR;
		else
			r.op = op_t'(3'($urandom_range(7, 5)));
		r.voice = 3'($urandom_range(7));
		sel = $urandom_range(99);
		if (sel < 3)
			r.effect_id = 8'd0;
		else if (sel < 15)
			r.effect_id = 8'($urandom_range(255));
		else
			r.effect_id = 8'($urandom_range(12, 1));
		r.sound_priority = 8'($urandom_range(255));
		r.singular = 1'($urandom_range(1));
		sel = $urandom_range(99);
		if (sel < 8)
			r.sample_count = 24'($urandom_range(3));
		else if (sel < 28)
			r.sample_count = 24'($urandom);
		else
			r.sample_count = 24'($urandom_range(5000, 4));
		r.has_origin = 1'($urandom_range(1));
		r.origin_id = ($urandom_range(99) < 80) ? 16'($urandom_range(7)) : 16'($urandom);
		r.volume = ($urandom_range(99) < 85) ? 7'($urandom_range(64)) : 7'($urandom_range(127));
		r.pan = 8'($urandom_range(255));
		return r;
	endfunction

	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else begin
			if (req_valid && !req_stall)
				allocation_q.push_back(allocate_voice(req));
			if (!req_valid || !req_stall) begin
				if (request_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					req_valid <= 1'b1;
					req <= request_q.pop_front();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (allocation_q.size() == 0) begin
					$error("response beat with no allocation outstanding");
					mismatches++;
				end else begin
					want = allocation_q.pop_front();
					if (rsp.granted !== want.granted) begin
						$error("granted: expected %0d, got %0d", want.granted, rsp.granted);
						mismatches++;
					end
					if (rsp.voice_out !== want.voice_out) begin
						$error("voice_out: expected %0d, got %0d", want.voice_out, rsp.voice_out);
						mismatches++;
					end
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp.status);
						mismatches++;
					end
					if (rsp.pan_out !== want.pan_out) begin
						$error("pan_out: expected %0d, got %0d", want.pan_out, rsp.pan_out);
						mismatches++;
					end
				end
			end
			rsp_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		send_idle_pct = 32;
		recv_stall_pct = 80;
		request_q.push_back(start_req(8'd1, 8'd0, 1'b0, 24'd0, 1'b0, 16'd0, 7'd0, 8'd0));
		request_q.push_back(start_req(8'd2, 8'd0, 1'b0, 24'd3, 1'b0, 16'd0, 7'd0, 8'd0));
		request_q.push_back(start_req(8'd255, 8'd255, 1'b1, 24'hFFFFFF, 1'b1, 16'hFFFF,
			7'd127, 8'd255));
		request_q.push_back(start_req(8'd0, 8'd0, 1'b0, 24'd4, 1'b0, 16'd0, 7'd64, 8'd0));
		request_q.push_back(start_req(8'd7, 8'd100, 1'b0, 24'd1000, 1'b0, 16'd0, 7'd10, 8'd1));
		request_q.push_back(start_req(8'd7, 8'd100, 1'b0, 24'd1000, 1'b0, 16'd0, 7'd5, 8'd2));
		request_q.push_back(start_req(8'd7, 8'd100, 1'b0, 24'd1000, 1'b0, 16'd0, 7'd20, 8'd3));
		request_q.push_back(event_req(OP_STARTED, 3'd5, 7'd0));
		request_q.push_back(start_req(8'd7, 8'd90, 1'b1, 24'd1000, 1'b0, 16'd0, 7'd30, 8'd40));
		request_q.push_back(event_req(OP_VOLUME, 3'd0, 7'd100));
		request_q.push_back(event_req(3'd5, 3'd2, 7'd0));
		request_q.push_back(event_req(3'd7, 3'd1, 7'd0));
		request_q.push_back(event_req(OP_FREE, 3'd3, 7'd0));
		request_q.push_back(start_req(8'd9, 8'd50, 1'b0, 24'd200, 1'b1, 16'hFFFF, 7'd10, 8'd77));
		request_q.push_back(event_req(OP_CLEAR, 3'd0, 7'd0));
		for (int i = 0; i < NV; i++)
			request_q.push_back(start_req(8'(20 + i), 8'd10, 1'b0, 24'd100, 1'b0, 16'd0,
				7'd32, 8'(i * 30)));
		request_q.push_back(start_req(8'd40, 8'd20, 1'b0, 24'd100, 1'b0, 16'd0, 7'd32, 8'd0));
		request_q.push_back(start_req(8'd41, 8'd5, 1'b0, 24'd100, 1'b0, 16'd0, 7'd32, 8'd0));
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 32;
					recv_stall_pct = 80;
				end
				1: begin
					send_idle_pct = 80;
					recv_stall_pct = 32;
				end
				default: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
			endcase
			repeat (567) request_q.push_back(random_request());
			while (request_q.size() > 0 || req_valid || allocation_q.size() > 0)
				@(negedge clk);
		end
		repeat (4 * NV + 32) @(negedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
